// ----- rtl/tgwr_pkg.sv -----
// ----------------------------------------------------------------------------
// tgwr_pkg
// Shared widths, codes, item layouts and sequencer states of the time-gap
// window rank block.
// ----------------------------------------------------------------------------
package tgwr_pkg;

    localparam int MAX_IMAGES_DEF = 1024;

    localparam int TS_W   = 32;
    localparam int IDX_W  = 10;
    localparam int RANK_W = 8;
    localparam int STAT_W = 2;
    localparam int SUM_W  = 32;
    localparam int GAP_W  = TS_W + 1;
    localparam int X_W    = GAP_W + 8;
    localparam int MSB_W  = 6;
    localparam int MANT_W = 31;
    localparam int FRAC_W = 16;
    localparam int CFGI_W = 2;
    localparam int CFGD_W = 8;
    localparam int WHW_W  = 6;

    localparam logic [CFGI_W-1:0] CFG_WHW  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_MAXR = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_STR  = 2'd2;

    localparam logic [WHW_W-1:0] WHW_RST  = 6'd9;
    localparam logic [7:0]       MAXR_RST = 8'd10;
    localparam logic [7:0]       STR_RST  = 8'd10;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd3;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [TS_W-1:0]  timestamp;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
    } t_cmd;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [STAT_W-1:0] status;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_APP_MUL,
        S_APP_NORM,
        S_APP_LOG,
        S_APP_WR,
        S_Q_RD1,
        S_Q_RD2,
        S_Q_RD3,
        S_Q_RD4,
        S_Q_RD5,
        S_Q_MUL,
        S_Q_SUB,
        S_Q_SAT,
        S_Q_DIV,
        S_RESULT
    } t_state;

endpackage

// ----- rtl/tgwr_fifo.sv -----
// ----------------------------------------------------------------------------
// tgwr_fifo
// Two-entry queue that decouples the request side, the engine and the
// result side.
// ----------------------------------------------------------------------------
module tgwr_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, n_wp;
    logic         r_rp, n_rp;
    logic [1:0]   r_cnt, n_cnt;
    logic         do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = do_push ? ~r_wp : r_wp;
        n_rp  = do_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ----- rtl/tgwr_back.sv -----
// ----------------------------------------------------------------------------
// tgwr_back
// Engine: prefix-sum store, iterative log2, window lookup and rank divider.
// ----------------------------------------------------------------------------
module tgwr_back #(
    parameter int MAX_IMAGES = tgwr_pkg::MAX_IMAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [tgwr_pkg::CFGI_W-1:0] i_cfg_index,
    input  logic [tgwr_pkg::CFGD_W-1:0] i_cfg_data,
    input  logic                        i_cmd_valid,
    input  tgwr_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_res_push,
    output tgwr_pkg::t_res              o_res,
    input  logic                        i_res_full
);
    import tgwr_pkg::*;

    localparam int CNT_W  = $clog2(MAX_IMAGES + 1);
    localparam int ADDR_W = $clog2(MAX_IMAGES);
    localparam int EW     = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
    localparam int P1_W   = SUM_W + 8;
    localparam int P2_W   = SUM_W + 2 + CNT_W;
    localparam int NUM_W  = ((P2_W > P1_W) ? P2_W : P1_W) + 1;
    localparam int DW     = NUM_W + 1;

    logic [SUM_W-1:0] r_mem [MAX_IMAGES];
    logic [SUM_W-1:0] r_rd_data;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [SUM_W-1:0] mem_wdata;

    t_state r_state, n_state;
    logic [WHW_W-1:0]  r_whw, n_whw;
    logic [7:0]        r_maxr, n_maxr;
    logic [7:0]        r_str, n_str;
    logic [TS_W-1:0]   r_last, n_last;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TS_W-1:0]   r_ts, n_ts;
    logic [GAP_W-1:0]  r_g, n_g;
    logic [X_W-1:0]    r_x, n_x;
    logic [MSB_W-1:0]  r_msb, n_msb;
    logic              r_zero, n_zero;
    logic [MANT_W-1:0] r_m, n_m;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [3:0]        r_step, n_step;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic [ADDR_W-1:0] r_a, n_a, r_b, n_b, r_start, n_start;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [SUM_W-1:0]  r_se, n_se, r_ss, n_ss, r_sb, n_sb, r_sa, n_sa;
    logic [SUM_W-1:0]  r_wsum, n_wsum;
    logic [P1_W-1:0]   r_p1, n_p1;
    logic signed [P2_W-1:0] r_p2, n_p2;
    logic [DW-1:0]     r_rem, n_rem, r_dv, n_dv;
    logic [RANK_W-1:0] r_q, n_q;
    logic [2:0]        r_bit, n_bit;
    t_res              r_res, n_res;

    logic [EW-1:0] a_e, b_e, cnt_e, w_e, lo_e, hi_e, st_e, last_e, end_e, nn_e;
    logic [CNT_W-1:0] cnt_m1;
    logic [TS_W-1:0]  tdiff;
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]  sq_t;
    logic [SUM_W-1:0] log_v, wsum_c;
    logic signed [SUM_W:0] gap;
    logic signed [NUM_W-1:0] num;
    logic [DW-1:0] dsh;

    assign o_res = r_res;

    always_comb begin
        n_state = r_state;
        n_whw = r_whw; n_maxr = r_maxr; n_str = r_str;
        n_last = r_last; n_count = r_count; n_ts = r_ts;
        n_g = r_g; n_x = r_x; n_msb = r_msb; n_zero = r_zero;
        n_m = r_m; n_frac = r_frac; n_step = r_step;
        n_rd_addr = r_rd_addr; n_a = r_a; n_b = r_b; n_start = r_start;
        n_n = r_n; n_se = r_se; n_ss = r_ss; n_sb = r_sb; n_sa = r_sa;
        n_wsum = r_wsum; n_p1 = r_p1; n_p2 = r_p2;
        n_rem = r_rem; n_dv = r_dv; n_q = r_q; n_bit = r_bit; n_res = r_res;
        o_cmd_pop = 1'b0;
        o_res_push = 1'b0;
        mem_we = 1'b0;
        mem_waddr = r_count[ADDR_W-1:0];
        mem_wdata = '0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WHW:  n_whw  = i_cfg_data[WHW_W-1:0];
                CFG_MAXR: n_maxr = i_cfg_data;
                CFG_STR:  n_str  = i_cfg_data;
                default: ;
            endcase
        end

        a_e    = {{(EW-IDX_W){1'b0}}, i_cmd.first_index};
        b_e    = {{(EW-IDX_W){1'b0}}, i_cmd.second_index};
        cnt_e  = {{(EW-CNT_W){1'b0}}, r_count};
        w_e    = {{(EW-WHW_W){1'b0}}, r_whw};
        lo_e   = (a_e < b_e) ? a_e : b_e;
        hi_e   = (a_e < b_e) ? b_e : a_e;
        st_e   = (lo_e < w_e) ? '0 : lo_e - w_e;
        last_e = cnt_e - EW'(1);
        end_e  = ((last_e - hi_e) < w_e) ? last_e : hi_e + w_e;
        nn_e   = end_e - st_e + EW'(1);
        cnt_m1 = r_count - CNT_W'(1);
        tdiff  = (i_cmd.timestamp >= r_last) ? i_cmd.timestamp - r_last
                                             : r_last - i_cmd.timestamp;
        sq     = r_m * r_m;
        sq_t   = sq[2*MANT_W-1:MANT_W-1];
        log_v  = r_zero ? '0 : {{(SUM_W-MSB_W-FRAC_W){1'b0}}, r_msb, r_frac};
        wsum_c = r_se - r_ss;
        gap    = $signed({1'b0, r_sb}) - $signed({1'b0, r_sa});
        num    = $signed({{(NUM_W-P1_W){1'b0}}, r_p1})
               - $signed({{(NUM_W-P2_W){r_p2[P2_W-1]}}, r_p2});
        dsh    = r_dv << r_bit;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_res.rank = '0;
                    n_res.status = STAT_OK;
                    n_state = S_RESULT;
                    if (i_cmd.req_type == REQ_APPEND) begin
                        if (r_count == CNT_W'(MAX_IMAGES)) begin
                            n_res.status = STAT_FULL;
                        end else if (r_count == '0) begin
                            mem_we  = 1'b1;
                            n_last  = i_cmd.timestamp;
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_ts      = i_cmd.timestamp;
                            n_g       = {1'b0, tdiff} + GAP_W'(1);
                            n_rd_addr = cnt_m1[ADDR_W-1:0];
                            n_state   = S_APP_MUL;
                        end
                    end else begin
                        if (a_e >= cnt_e || b_e >= cnt_e) begin
                            n_res.status = STAT_RANGE;
                        end else begin
                            n_a       = a_e[ADDR_W-1:0];
                            n_b       = b_e[ADDR_W-1:0];
                            n_start   = st_e[ADDR_W-1:0];
                            n_n       = nn_e[CNT_W-1:0];
                            n_rd_addr = end_e[ADDR_W-1:0];
                            n_state   = S_Q_RD1;
                        end
                    end
                end
            end
            S_APP_MUL: begin
                n_x     = r_g * r_str;
                n_msb   = MSB_W'(X_W - 1);
                n_state = S_APP_NORM;
            end
            S_APP_NORM: begin
                // shift left until the top bit is set or the value is zero
                if (r_x[X_W-1] || r_x == '0) begin
                    n_zero  = (r_x == '0);
                    n_m     = r_x[X_W-1 -: MANT_W];
                    n_frac  = '0;
                    n_step  = '0;
                    n_state = S_APP_LOG;
                end else begin
                    n_x   = r_x << 1;
                    n_msb = r_msb - MSB_W'(1);
                end
            end
            S_APP_LOG: begin
                // square, then halve when the square reaches two
                n_frac = {r_frac[FRAC_W-2:0], sq_t[MANT_W]};
                n_m    = sq_t[MANT_W] ? sq_t[MANT_W:1] : sq_t[MANT_W-1:0];
                n_step = r_step + 4'd1;
                if (r_step == 4'd15) n_state = S_APP_WR;
            end
            S_APP_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data + log_v;
                n_last    = r_ts;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_RESULT;
            end
            S_Q_RD1: begin
                n_rd_addr = r_start;
                n_state   = S_Q_RD2;
            end
            S_Q_RD2: begin
                n_se      = r_rd_data;
                n_rd_addr = r_b;
                n_state   = S_Q_RD3;
            end
            S_Q_RD3: begin
                n_ss      = r_rd_data;
                n_rd_addr = r_a;
                n_state   = S_Q_RD4;
            end
            S_Q_RD4: begin
                n_sb    = r_rd_data;
                n_state = S_Q_RD5;
            end
            S_Q_RD5: begin
                n_sa    = r_rd_data;
                n_state = S_Q_MUL;
            end
            S_Q_MUL: begin
                n_wsum = wsum_c;
                n_p1   = r_maxr * wsum_c;
                n_p2   = gap * $signed({1'b0, r_n});
                if (wsum_c == '0) begin
                    n_res.status = STAT_ZERO;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_Q_SUB;
                end
            end
            S_Q_SUB: begin
                if (num[NUM_W-1] || num == '0) begin
                    n_state = S_RESULT;
                end else begin
                    n_rem   = {num, 1'b0} + DW'(r_wsum);
                    n_dv    = {{(DW-SUM_W-1){1'b0}}, r_wsum, 1'b0};
                    n_state = S_Q_SAT;
                end
            end
            S_Q_SAT: begin
                n_q   = '0;
                n_bit = 3'd7;
                if (r_rem >= (r_dv << 8)) begin
                    n_res.rank = '1;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_Q_DIV;
                end
            end
            S_Q_DIV: begin
                if (r_rem >= dsh) begin
                    n_rem = r_rem - dsh;
                    n_q[r_bit] = 1'b1;
                end
                n_bit = r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    n_res.rank = n_q;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // hold until the result queue has room
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_whw   <= WHW_RST;
            r_maxr  <= MAXR_RST;
            r_str   <= STR_RST;
            r_last  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_whw   <= n_whw;
            r_maxr  <= n_maxr;
            r_str   <= n_str;
            r_last  <= n_last;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts <= n_ts; r_g <= n_g; r_x <= n_x; r_msb <= n_msb; r_zero <= n_zero;
        r_m <= n_m; r_frac <= n_frac; r_step <= n_step; r_rd_addr <= n_rd_addr;
        r_a <= n_a; r_b <= n_b; r_start <= n_start; r_n <= n_n;
        r_se <= n_se; r_ss <= n_ss; r_sb <= n_sb; r_sa <= n_sa;
        r_wsum <= n_wsum; r_p1 <= n_p1; r_p2 <= n_p2;
        r_rem <= n_rem; r_dv <= n_dv; r_q <= n_q; r_bit <= n_bit; r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rd_data <= r_mem[r_rd_addr];
    end
endmodule

// ----- rtl/time_gap_window_rank.sv -----
// ----------------------------------------------------------------------------
// time_gap_window_rank
// Log time-gap prefix-sum store with windowed similarity rank queries.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   push / full               i_req_type i_timestamp i_first_index
//                                      i_second_index
//  result    empty / pop               o_rank o_status
//  config    i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// An append runs the normalizing shift of the scaled gap and then the squaring
// log2 loop. A query makes four reads through the single store port, two
// multiplies and an 8-step restoring divider. Out-of-range queries and
// full-store appends go straight to the result. Reset is synchronous and
// clears the count and last stamp and restores the configuration defaults;
// the store needs no clearing. Two-entry queues on each side let requests
// arrive and results wait while the engine works.
module time_gap_window_rank #(
    parameter int MAX_IMAGES = tgwr_pkg::MAX_IMAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_req_type,
    input  logic [tgwr_pkg::TS_W-1:0]   i_timestamp,
    input  logic [tgwr_pkg::IDX_W-1:0]  i_first_index,
    input  logic [tgwr_pkg::IDX_W-1:0]  i_second_index,
    output logic                        empty,
    input  logic                        pop,
    output logic [tgwr_pkg::RANK_W-1:0] o_rank,
    output logic [tgwr_pkg::STAT_W-1:0] o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tgwr_pkg::CFGI_W-1:0] i_cfg_index,
    input  logic [tgwr_pkg::CFGD_W-1:0] i_cfg_data
);
    import tgwr_pkg::*;

    t_cmd in_cmd, q_cmd;
    t_res e_res, q_res;
    logic cmd_empty, cmd_pop, res_push, res_full;

    assign o_cfg_ready = 1'b1;
    assign in_cmd.req_type     = i_req_type;
    assign in_cmd.timestamp    = i_timestamp;
    assign in_cmd.first_index  = i_first_index;
    assign in_cmd.second_index = i_second_index;
    assign o_rank   = q_res.rank;
    assign o_status = q_res.status;

    tgwr_fifo #(.W($bits(t_cmd))) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_cmd),
        .o_full  (full),
        .o_empty (cmd_empty),
        .i_pop   (cmd_pop),
        .o_data  (q_cmd)
    );

    tgwr_back #(.MAX_IMAGES(MAX_IMAGES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (e_res),
        .i_res_full  (res_full)
    );

    tgwr_fifo #(.W($bits(t_res))) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (e_res),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (q_res)
    );
endmodule
